// File: sv/fpfa_pkg.sv
`default_nettype none
package fpfa_pkg;

  localparam int unsigned BLOCK_SLOTS = 16;
  localparam int unsigned SIZE_BITS   = 16;

  localparam int unsigned IDX_W = $clog2(BLOCK_SLOTS);
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam int unsigned SUM_W = SIZE_BITS + IDX_W + 1;
  localparam int unsigned TOT_W = 20;
  localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};

  typedef logic [SIZE_BITS-1:0] size_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [SUM_W-1:0]     sum_t;
  typedef logic [TOT_W-1:0]     tot_t;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_ALLOC = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    POL_BEST  = 2'd0,
    POL_WORST = 2'd1,
    POL_FIRST = 2'd2,
    POL_NEXT  = 2'd3
  } policy_e;

  typedef enum logic {
    CFG_POLICY      = 1'b0,
    CFG_BLOCK_COUNT = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_e;

endpackage
`default_nettype wire

// File: sv/fpfa_ram.sv
`default_nettype none
module fpfa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: sv/fixed_partition_fit_allocator_unit.sv
`default_nettype none
// Fixed-partition fit allocator.
// Input stream (s_axis): one beat per operation; tuser carries the op code
// (load block size, clear all allocations, allocate). Output stream (m_axis):
// exactly one result beat per input beat, in order.
// Config channel (cfg_*): index 0 is the fit policy (best, worst, first,
// next), index 1 the number of blocks in use; always ready, so write only while idle.
// Block sizes sit in a 16 x 16 synchronous RAM; taken marks and per-entry
// valid bits are flops, so an entry never loaded reads as size zero.
// Every op walks the blocks in use through the single RAM read port, one
// entry a cycle, summing free sizes and tracking the fit candidate; the
// next beat is taken the cycle after the item reaches the result register.
// A load writes the RAM in its accept cycle, a clear drops all marks then.
// The result sits in an output register: a stalled receiver holds it and
// the unit may finish scanning the next item meanwhile, but it will not
// retire that item until the register is free.
// Reset (rst_ni low, asynchronous): all blocks free and size zero, totals
// and next-fit resume point zero, policy best fit, sixteen blocks in use.
module fixed_partition_fit_allocator_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [3:0] block_slot, [19:4] size_kb
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] op
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // [3:0] granted_block, [19:4] leftover,
                                           // [39:20] internal_total, [59:40] free_total
  output logic             m_axis_tuser,   // [0] granted
  // config writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [4:0]  cfg_data_i
);
  import fpfa_pkg::*;

  // config
  policy_e    policy_q;
  logic [4:0] block_count_q;

  // allocator state
  logic [BLOCK_SLOTS-1:0] taken_q;
  logic [BLOCK_SLOTS-1:0] loaded_q;
  idx_t                   resume_q;
  tot_t                   lsum_q;

  // item in flight
  state_e state_q, state_d;
  op_e    op_q;
  size_t  req_q;
  cnt_t   cnt_q;
  logic   rv_q;
  idx_t   ri_q;
  sum_t   sum_q;
  logic   found_q, hi_found_q;
  idx_t   pick_q, hi_pick_q;
  size_t  pick_sz_q, hi_sz_q;
  size_t  pick_d_q, hi_d_q;

  // output register
  logic   m_valid_q;
  logic   o_granted_q;
  idx_t   o_blk_q;
  size_t  o_left_q;
  tot_t   o_itot_q, o_ftot_q;

  logic  in_acc, issue, out_load;
  cnt_t  n_act;
  idx_t  start;
  size_t ram_rdata, in_size, e_size, e_diff;
  idx_t  in_slot;
  logic  e_free, e_fit, upd, hi_upd;
  logic  g_any;
  idx_t  g_pick;
  size_t g_size, g_left;
  sum_t  free_raw;
  logic [TOT_W:0] lsum_raw;
  tot_t  lsum_new, ftot_new;

  assign cfg_ready_o = 1'b1;
  assign in_slot     = idx_t'(s_axis_tdata[3:0]);
  assign in_size     = size_t'(s_axis_tdata[19:4]);
  assign in_acc      = s_axis_tvalid && s_axis_tready;

  assign n_act = (cnt_t'(block_count_q) > cnt_t'(BLOCK_SLOTS)) ? cnt_t'(BLOCK_SLOTS)
                                                               : cnt_t'(block_count_q);
  assign start = (cnt_t'(resume_q) < n_act) ? resume_q : '0;
  assign issue = (state_q == ST_SCAN) && (cnt_q < n_act);

  fpfa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (BLOCK_SLOTS)
  ) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && (op_e'(s_axis_tuser) == OP_LOAD)),
    .waddr_i (in_slot),
    .wdata_i (in_size),
    .re_i    (issue),
    .raddr_i (cnt_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // entry evaluation, one block per cycle
  always_comb begin
    e_size = loaded_q[ri_q] ? ram_rdata : '0;
    e_free = !taken_q[ri_q];
    e_fit  = (op_q == OP_ALLOC) && e_free && (e_size >= req_q);
    e_diff = e_size - req_q;
    upd    = 1'b0;
    unique case (policy_q)
      POL_BEST:  upd = e_fit && (!found_q || (e_diff < pick_d_q));
      POL_WORST: upd = e_fit && (!found_q || (e_diff > pick_d_q));
      POL_FIRST,
      POL_NEXT:  upd = e_fit && !found_q;
      default:   upd = 1'b0;
    endcase
    // next fit: first candidate at or after the resume point wins
    hi_upd = e_fit && !hi_found_q && (ri_q >= start);
  end

  // final choice and totals
  always_comb begin
    if (policy_q == POL_NEXT && hi_found_q) begin
      g_any  = 1'b1;
      g_pick = hi_pick_q;
      g_size = hi_sz_q;
      g_left = hi_d_q;
    end else begin
      g_any  = found_q;
      g_pick = pick_q;
      g_size = pick_sz_q;
      g_left = pick_d_q;
    end
    // every term is non-negative, so clamping once equals clamping per add
    free_raw = sum_q - (g_any ? sum_t'(g_size) : '0);
    ftot_new = (free_raw > sum_t'(TOTAL_MAX)) ? TOTAL_MAX : tot_t'(free_raw);
    lsum_raw = {1'b0, lsum_q} + (g_any ? (TOT_W+1)'(g_left) : '0);
    lsum_new = (lsum_raw > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : tot_t'(lsum_raw);
  end

  // sequencer
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!issue && !rv_q) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q      <= POL_BEST;
      block_count_q <= 5'd16;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_POLICY:      policy_q      <= policy_e'(cfg_data_i[1:0]);
        CFG_BLOCK_COUNT: block_count_q <= cfg_data_i;
        default:         ;
      endcase
    end
  end

  // allocator state and scan control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q    <= '0;
      loaded_q   <= '0;
      resume_q   <= '0;
      lsum_q     <= '0;
      rv_q       <= 1'b0;
      cnt_q      <= '0;
      found_q    <= 1'b0;
      hi_found_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      rv_q <= issue;
      if (issue) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (in_acc) begin
        cnt_q      <= '0;
        found_q    <= 1'b0;
        hi_found_q <= 1'b0;
        unique case (op_e'(s_axis_tuser))
          OP_LOAD:  loaded_q[in_slot] <= 1'b1;
          OP_CLEAR: begin
            taken_q  <= '0;
            lsum_q   <= '0;
            resume_q <= '0;
          end
          OP_ALLOC,
          OP_NOP:   ;
          default:  ;
        endcase
      end
      if (rv_q && upd) begin
        found_q <= 1'b1;
      end
      if (rv_q && hi_upd) begin
        hi_found_q <= 1'b1;
      end
      if (out_load && g_any) begin
        taken_q[g_pick] <= 1'b1;
        resume_q        <= g_pick;
        lsum_q          <= lsum_new;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= op_e'(s_axis_tuser);
      req_q <= in_size;
      sum_q <= '0;
    end
    ri_q <= cnt_q[IDX_W-1:0];
    if (rv_q && e_free) begin
      sum_q <= sum_q + sum_t'(e_size);
    end
    if (rv_q && upd) begin
      pick_q    <= ri_q;
      pick_sz_q <= e_size;
      pick_d_q  <= e_diff;
    end
    if (rv_q && hi_upd) begin
      hi_pick_q <= ri_q;
      hi_sz_q   <= e_size;
      hi_d_q    <= e_diff;
    end
    if (out_load) begin
      o_granted_q <= g_any;
      o_blk_q     <= g_any ? g_pick : '0;
      o_left_q    <= g_any ? g_left : '0;
      o_itot_q    <= g_any ? lsum_new : lsum_q;
      o_ftot_q    <= ftot_new;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = o_granted_q;
  assign m_axis_tdata  = {4'd0, 20'(o_ftot_q), 20'(o_itot_q), 16'(o_left_q), 4'(o_blk_q)};

endmodule
`default_nettype wire
